[hw/rtl/rgtf_pkg.sv]
// shared types and constants of the radar gate texture filter
package rgtf_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int TEX_W          = 20;
   localparam int RADIUS_W       = 6;
   localparam int CSR_IDX_W      = 1;
   localparam int MAX_RADIUS_DEF = 40;

   localparam logic [SAMPLE_W-1:0] BLANK_RESET  = 16'h8000;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd40;

   localparam logic [CSR_IDX_W-1:0] REG_BLANK_CODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_RADIUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FIND,
      ST_ACCUM,
      ST_EVAL,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic shift_in;
      logic rotate;
   } cell_ctrl_type;

endpackage

[hw/rtl/radar_gate_texture_filter.sv]
// top level: gate ring of cells, window walk, divider and square root per result
// each result rotates the ring for the center search, then again for the window walk, then runs
//   the divider and square root when the result is valid
// one item at a time; a finished word waits in the output register while the next is taken
// synchronous active high reset clears control state, the csr registers and output valid;
//   the ring needs no clearing
module radar_gate_texture_filter #(
   parameter int MAX_RADIUS = rgtf_pkg::MAX_RADIUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // sample
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // texture_q4, zero fill
   output logic                               rsp_tuser,   // is_valid
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rgtf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                        csr_data
);

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int AGE_W = $clog2(DEPTH + 2);
   localparam int PC_W  = $clog2(MAX_RADIUS + 2);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = 32 + CNT_W;
   localparam int QW    = SUM_W + 8;
   localparam int SQ_W  = QW + (QW % 2);
   localparam int SW_   = rgtf_pkg::SAMPLE_W;

   rgtf_pkg::state_type state_ff, state_in;
   rgtf_pkg::cell_ctrl_type cell_ctrl;

   logic signed [SW_-1:0] blank_ff, blank_in;
   logic [rgtf_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [PC_W-1:0]  o_ff, o_in, p_ff, p_in;
   logic             last_ff, last_in, fin_ff, fin_in, good_ff, good_in;
   logic [AGE_W-1:0] k_ff, k_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SW_-1:0] center_ff, center_in;
   logic             s1_hit_ff, s1_hit_in, s2_hit_ff, s2_hit_in;
   logic [SW_-1:0]   s1_d_ff, s1_d_in;
   logic [31:0]      s2_prod_ff, s2_prod_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [rgtf_pkg::TEX_W-1:0] rsp_tex_ff, rsp_tex_in;

   logic accept, emit_cond, out_load, div_start, sqrt_start, div_done, sqrt_done;
   logic [rgtf_pkg::RADIUS_W-1:0] rad_clip;
   logic [PC_W-1:0]  r_eff, o_trim, o_next;
   logic [AGE_W-1:0] center_age, ahead_min;
   logic [QW-1:0]    quotient;
   logic [SQ_W/2-1:0] root;
   logic signed [SW_:0] diff;
   logic signed [SW_-1:0] tap;
   logic signed [SW_-1:0] cell_val [DEPTH];

   // gate ring
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [SW_-1:0] newer_val, older_val;
      if (i == 0) begin : g_head
         assign newer_val = $signed(req_tdata);
      end else begin : g_mid
         assign newer_val = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign older_val = cell_val[0];
      end else begin : g_body
         assign older_val = cell_val[i+1];
      end
      rgtf_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .newer_val  (newer_val),
         .older_val  (older_val),
         .cell_value (cell_val[i])
      );
   end

   assign tap = cell_val[0];

   rgtf_div #(.QW(QW), .DW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, 8'd0}),
      .divisor  (n_ff - 1'b1),
      .done     (div_done),
      .quotient (quotient)
   );

   rgtf_sqrt #(.SW(SQ_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (SQ_W'(quotient)),
      .done     (sqrt_done),
      .root     (root)
   );

   assign rad_clip = (radius_ff == '0) ? rgtf_pkg::RADIUS_W'(1) :
                     ({1'b0, radius_ff} > 7'(MAX_RADIUS)) ? rgtf_pkg::RADIUS_W'(MAX_RADIUS) :
                     radius_ff;
   assign r_eff      = PC_W'(rad_clip);
   assign o_trim     = (o_ff > r_eff) ? r_eff : o_ff;
   assign o_next     = (o_ff + 1'b1 > r_eff) ? r_eff : PC_W'(o_ff + 1'b1);
   assign center_age = AGE_W'(p_ff) - 1'b1;
   assign ahead_min  = (center_age > AGE_W'(r_eff)) ? AGE_W'(r_eff) : center_age;
   assign emit_cond  = last_ff ? (p_ff != '0) : (p_ff > r_eff);
   assign accept     = req_tvalid && req_tready;
   assign diff       = {center_ff[SW_-1], center_ff} - {tap[SW_-1], tap};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgtf_pkg::ST_IDLE:  if (accept) state_in = rgtf_pkg::ST_CHECK;
         rgtf_pkg::ST_CHECK: state_in = emit_cond ? rgtf_pkg::ST_FIND : rgtf_pkg::ST_IDLE;
         rgtf_pkg::ST_FIND:  if (k_ff == AGE_W'(DEPTH - 1)) state_in = rgtf_pkg::ST_ACCUM;
         rgtf_pkg::ST_ACCUM: if (k_ff == AGE_W'(DEPTH + 1)) state_in = rgtf_pkg::ST_EVAL;
         rgtf_pkg::ST_EVAL: begin
            state_in = (center_ff > blank_ff && n_ff > CNT_W'(1)) ? rgtf_pkg::ST_DIV
                                                                  : rgtf_pkg::ST_OUT;
         end
         rgtf_pkg::ST_DIV:   if (div_done) state_in = rgtf_pkg::ST_SQRT;
         rgtf_pkg::ST_SQRT:  if (sqrt_done) state_in = rgtf_pkg::ST_OUT;
         rgtf_pkg::ST_OUT:   if (out_load) state_in = rgtf_pkg::ST_CHECK;
         default:            state_in = rgtf_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready         = (state_ff == rgtf_pkg::ST_IDLE) && !reset;
      cell_ctrl.shift_in = req_tvalid && (state_ff == rgtf_pkg::ST_IDLE) && !reset;
      cell_ctrl.rotate   = (state_ff == rgtf_pkg::ST_FIND) ||
                           (state_ff == rgtf_pkg::ST_ACCUM && k_ff < AGE_W'(DEPTH));
      div_start          = (state_ff == rgtf_pkg::ST_EVAL) && center_ff > blank_ff &&
                           n_ff > CNT_W'(1);
      sqrt_start         = (state_ff == rgtf_pkg::ST_DIV) && div_done;
      out_load           = (state_ff == rgtf_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // datapath
   always_comb begin
      blank_in     = blank_ff;
      radius_in    = radius_ff;
      o_in         = o_ff;
      p_in         = p_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;
      good_in      = good_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      center_in    = center_ff;
      s1_hit_in    = 1'b0;
      s1_d_in      = diff[SW_-1:0];
      s2_hit_in    = s1_hit_ff;
      s2_prod_in   = 32'(s1_d_ff) * 32'(s1_d_ff);
      sum_in       = sum_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_tex_in   = rsp_tex_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            rgtf_pkg::REG_BLANK_CODE:    blank_in  = $signed(csr_data);
            rgtf_pkg::REG_WINDOW_RADIUS: radius_in = csr_data[rgtf_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         o_in    = o_trim;
         p_in    = p_ff + 1'b1;
         last_in = req_tlast;
      end

      case (state_ff)
         rgtf_pkg::ST_CHECK: begin
            k_in   = '0;
            sum_in = '0;
            n_in   = '0;
            lo_in  = center_age - ahead_min;
            hi_in  = center_age + AGE_W'(o_ff);
            fin_in = last_ff && (p_ff == PC_W'(1));
            if (!emit_cond && last_ff) begin
               o_in = '0;
               p_in = '0;
            end
         end
         rgtf_pkg::ST_FIND: begin
            if (k_ff == center_age) center_in = tap;
            k_in = (k_ff == AGE_W'(DEPTH - 1)) ? '0 : k_ff + 1'b1;
         end
         rgtf_pkg::ST_ACCUM: begin
            k_in      = k_ff + 1'b1;
            s1_hit_in = (k_ff < AGE_W'(DEPTH)) && k_ff >= lo_ff && k_ff <= hi_ff &&
                        tap > blank_ff && tap <= center_ff;
            if (s2_hit_ff) begin
               sum_in = sum_ff + SUM_W'(s2_prod_ff);
               n_in   = n_ff + 1'b1;
            end
         end
         rgtf_pkg::ST_EVAL: good_in = center_ff > blank_ff && n_ff > CNT_W'(1);
         rgtf_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = good_ff;
               rsp_last_in  = fin_ff;
               rsp_tex_in   = good_ff ? root[rgtf_pkg::TEX_W-1:0] : '0;
               o_in         = o_next;
               p_in         = p_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgtf_pkg::ST_IDLE;
         blank_ff     <= rgtf_pkg::BLANK_RESET;
         radius_ff    <= rgtf_pkg::RADIUS_RESET;
         o_ff         <= '0;
         p_ff         <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_hit_ff    <= 1'b0;
         s2_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blank_ff     <= blank_in;
         radius_ff    <= radius_in;
         o_ff         <= o_in;
         p_ff         <= p_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_hit_ff    <= s1_hit_in;
         s2_hit_ff    <= s2_hit_in;
      end
      fin_ff     <= fin_in;
      good_ff    <= good_in;
      k_ff       <= k_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      center_ff  <= center_in;
      s1_d_ff    <= s1_d_in;
      s2_prod_ff <= s2_prod_in;
      sum_ff     <= sum_in;
      n_ff       <= n_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_tex_ff  <= rsp_tex_in;
   end

   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_tex_ff};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      p_ff <= PC_W'(MAX_RADIUS + 1))
      else $error("pending count out of range");

   a_div_needs_two: assert property (@(posedge clock) disable iff (reset)
      div_start |-> n_ff > CNT_W'(1))
      else $error("divider started with too few gates");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == rgtf_pkg::ST_OUT))
      else $error("result word appeared outside output state");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rgtf_pkg::ST_CHECK)
      else $error("accepted word not followed by check");

endmodule

[hw/rtl/rgtf_cell.sv]
// one gate cell of the sample ring, shifts in from the newer side or rotates from the older side
module rgtf_cell (
   input  logic                                  clock,
   input  rgtf_pkg::cell_ctrl_type               ctrl,
   input  logic signed [rgtf_pkg::SAMPLE_W-1:0]  newer_val,
   input  logic signed [rgtf_pkg::SAMPLE_W-1:0]  older_val,
   output logic signed [rgtf_pkg::SAMPLE_W-1:0]  cell_value
);

   logic signed [rgtf_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [rgtf_pkg::SAMPLE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_in) begin
         value_in = newer_val;
      end else if (ctrl.rotate) begin
         value_in = older_val;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

[hw/rtl/rgtf_div.sv]
// restoring divider, one quotient bit per cycle
module rgtf_div #(
   parameter int QW = 47,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] dq_ff, dq_in;
   logic [DW:0]   shifted;
   logic          qbit;

   always_comb begin
      shifted = {rem_ff, dq_ff[QW-1]};
      qbit    = (shifted >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in = qbit ? DW'(shifted - {1'b0, dvs_ff}) : DW'(shifted);
         dq_in  = {dq_ff[QW-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[hw/rtl/rgtf_sqrt.sv]
// digit by digit integer square root, one result bit per cycle
module rgtf_sqrt #(
   parameter int SW = 48
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SW-1:0]   radicand,
   output logic            done,
   output logic [SW/2-1:0] root
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] x_ff, x_in;
   logic [SW-1:0] res_ff, res_in;
   logic [SW-1:0] bit_ff, bit_in;
   logic [SW-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         res_in  = '0;
         bit_in  = SW'(1) << (SW - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[SW/2-1:0];

endmodule

[tb/sv/tb_top.sv]
// testbench of the radar gate texture filter: ray stimulus, window deviation predictor, checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = 2 * rgtf_pkg::MAX_RADIUS_DEF + 1;
   localparam int STALL_LIMIT = 50000;
   localparam int SETTLE = 600;

   typedef struct {
      logic [rgtf_pkg::TEX_W-1:0] texture_q4;
      logic             is_valid;
      logic             last_result;
   } texture_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rgtf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   radar_gate_texture_filter uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   texture_word_type expected_textures[$];
   int errors = 0;
   bit idle_on = 1'b1;
   int quiet_cycles = 0;

   logic signed [15:0] ray_gates[WIN];
   int kept_gates, waiting_gates;
   logic signed [15:0] blank_level;
   int radius_reg;

   function automatic int clamp_radius();
      if (radius_reg < 1) return 1;
      if (radius_reg > rgtf_pkg::MAX_RADIUS_DEF) return rgtf_pkg::MAX_RADIUS_DEF;
      return radius_reg;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic void drop_old_gates(int r);
      int drop;
      if (kept_gates > r) begin
         drop = kept_gates - r;
         for (int i = 0; i < r + waiting_gates; i++) ray_gates[i] = ray_gates[i + drop];
         kept_gates = r;
      end
   endfunction

   function automatic void predict_texture(int r, bit fin);
      int c, lo, hi, ahead;
      logic signed [15:0] center;
      longint unsigned sum, n, d, root_v;
      texture_word_type w;
      c = kept_gates;
      ahead = waiting_gates - 1;
      lo = c - ((kept_gates < r) ? kept_gates : r);
      hi = c + ((ahead < r) ? ahead : r);
      if (hi > WIN - 1) hi = WIN - 1;
      center = ray_gates[(c < WIN) ? c : 0];
      sum = 0;
      n = 0;
      w.texture_q4 = '0;
      w.is_valid = 1'b0;
      w.last_result = fin;
      if (center > blank_level) begin
         for (int i = lo; i <= hi; i++) begin
            if (ray_gates[i] > blank_level && ray_gates[i] <= center) begin
               d = longint'(center) - longint'(ray_gates[i]);
               sum += d * d;
               n++;
            end
         end
         if (n > 1) begin
            root_v = int_sqrt((sum * 256) / (n - 1));
            w.texture_q4 = root_v[rgtf_pkg::TEX_W-1:0];
            w.is_valid = 1'b1;
         end
      end
      expected_textures.push_back(w);
      kept_gates++;
      waiting_gates--;
      drop_old_gates(r);
   endfunction

   function automatic void take_gate(logic signed [15:0] sample, bit last);
      int r, pos;
      r = clamp_radius();
      drop_old_gates(r);
      pos = kept_gates + waiting_gates;
      if (pos > WIN - 1) pos = WIN - 1;
      ray_gates[pos] = sample;
      waiting_gates = pos - kept_gates + 1;
      if (last) begin
         while (waiting_gates > 0) predict_texture(r, waiting_gates == 1);
         kept_gates = 0;
         waiting_gates = 0;
      end else begin
         while (waiting_gates > r) predict_texture(r, 1'b0);
      end
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      texture_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         quiet_cycles <= 0;
         if (expected_textures.size() == 0) begin
            $error("unexpected word: tdata %h", rsp_tdata);
            errors++;
         end else begin
            w = expected_textures.pop_front();
            if (rsp_tdata !== {4'b0, w.texture_q4}) begin
               $error("texture_q4 expected %h actual %h", w.texture_q4, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== w.is_valid) begin
               $error("is_valid expected %b actual %b", w.is_valid, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== w.last_result) begin
               $error("last_result expected %b actual %b", w.last_result, rsp_tlast);
               errors++;
            end
         end
      end else if ((req_tvalid && req_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      rsp_tready <= !(idle_on && $urandom_range(99) < 33);
   end

   always @(posedge clock) begin
      if (quiet_cycles > STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_gate(logic signed [15:0] sample, bit last);
      if (idle_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      take_gate(sample, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_textures.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [rgtf_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == rgtf_pkg::REG_BLANK_CODE) blank_level = value;
      else if (idx == rgtf_pkg::REG_WINDOW_RADIUS) radius_reg = value[rgtf_pkg::RADIUS_W-1:0];
   endtask

   task automatic send_ray(int len, int base, int spread, int blank_pct);
      int v;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < blank_pct) v = int'(blank_level) - int'($urandom_range(0, 3));
         else if ($urandom_range(99) < 10) v = $urandom_range(0, 65535) - 32768;
         else v = base + $urandom_range(0, 2 * spread) - spread;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         send_gate(16'(v), i == len - 1);
      end
   endtask

   task automatic test_single_gate_rays();
      send_gate(16'sd100, 1'b1);
      send_gate(-16'sd32767, 1'b1);
      send_gate(16'sh8000, 1'b1);
      drain();
   endtask

   task automatic test_extremes();
      write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'd2);
      send_gate(16'sh7fff, 1'b0);
      send_gate(-16'sd32767, 1'b0);
      send_gate(16'sh7fff, 1'b0);
      send_gate(16'sh7fff, 1'b0);
      send_gate(-16'sd32767, 1'b0);
      send_gate(16'sd0, 1'b1);
      drain();
   endtask

   task automatic test_blank_handling();
      write_reg(rgtf_pkg::REG_BLANK_CODE, 16'd0);
      write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'd1);
      send_gate(16'sd0, 1'b0);
      send_gate(16'sd5, 1'b0);
      send_gate(16'sd1, 1'b0);
      send_gate(-16'sd4, 1'b0);
      send_gate(16'sd9, 1'b1);
      drain();
      write_reg(rgtf_pkg::REG_BLANK_CODE, 16'sh7fff);
      send_gate(16'sh7fff, 1'b0);
      send_gate(16'sd3, 1'b1);
      drain();
      write_reg(rgtf_pkg::REG_BLANK_CODE, 16'h8000);
   endtask

   task automatic test_radius_clamp();
      write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'd0);
      send_ray(6, 200, 50, 0);
      drain();
      write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'hffff);
      send_ray(45, -1000, 3000, 5);
      drain();
   endtask

   task automatic test_random_rays();
      int len;
      for (int k = 0; k < 20; k++) begin
         idle_on = !(k >= 10 && k < 14);
         if ($urandom_range(99) < 40) begin
            write_reg(rgtf_pkg::REG_BLANK_CODE, 16'($urandom_range(0, 65535)));
         end else if ($urandom_range(99) < 50) begin
            write_reg(rgtf_pkg::REG_BLANK_CODE, 16'h8000);
         end else begin
            write_reg(rgtf_pkg::REG_BLANK_CODE, 16'($urandom_range(0, 400) - 200));
         end
         if (k % 9 == 8) begin
            write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'd40);
            len = $urandom_range(41, 50);
         end else begin
            write_reg(rgtf_pkg::REG_WINDOW_RADIUS, 16'($urandom_range(1, 6)));
            len = $urandom_range(1, 8);
         end
         send_ray(len, $urandom_range(0, 60000) - 30000, $urandom_range(1, 2000), 15);
         drain();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      kept_gates = 0;
      waiting_gates = 0;
      blank_level = rgtf_pkg::BLANK_RESET;
      radius_reg = rgtf_pkg::RADIUS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_gate_rays();
      test_extremes();
      test_blank_handling();
      test_radius_clamp();
      test_random_rays();
      if (errors == 0 && expected_textures.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
